@@ design/dsrt_pkg.sv @@
// Shared constants, types and status codes of the datagram slice reassembly tracker.
package dsrt_pkg;

    localparam int CONTEXTS      = 8;
    localparam int SLICES        = 256;
    localparam int SLICE_BYTES   = 256;
    localparam int HEADER_BYTES  = 16;

    localparam logic [15:0] MAGIC_VALUE   = 16'hCDEA;
    localparam logic [7:0]  VERSION_VALUE = 8'd1;
    localparam logic [7:0]  KIND_CHUNK    = 8'd1;

    localparam int CTX_W = (CONTEXTS > 1) ? $clog2(CONTEXTS) : 1;
    localparam int SEQ_W = $clog2(SLICES);
    localparam int RCV_W = $clog2(SLICES + 1);

    localparam int S_DATA_W = 144;
    localparam int M_DATA_W = 24;

    localparam logic OP_PACKET = 1'b0;
    localparam logic OP_TICK   = 1'b1;

    typedef enum logic [2:0] {
        ST_NEW       = 3'd0,
        ST_DUP       = 3'd1,
        ST_MALFORMED = 3'd2,
        ST_FULL      = 3'd3,
        ST_DONE      = 3'd4
    } status_t;

    typedef struct packed {
        logic [8:0]         byte_length;
        logic [15:0]        magic_word;
        logic [7:0]         proto_version;
        logic [7:0]         packet_kind;
        logic signed [31:0] coord_x;
        logic signed [31:0] coord_z;
        logic [15:0]        slice_seq;
        logic [15:0]        slice_total;
    } hdr_t;

endpackage

@@ design/dsrt_hdr_check.sv @@
// Header validation: length, magic, version, type, slice total and sequence range.
module dsrt_hdr_check (
    input  dsrt_pkg::hdr_t hdr,
    output logic           hdr_ok
);
    import dsrt_pkg::*;

    logic len_ok;
    logic total_ok;
    logic seq_ok;

    assign len_ok   = {23'd0, hdr.byte_length} == 32'(HEADER_BYTES + SLICE_BYTES);
    assign total_ok = {16'd0, hdr.slice_total} == 32'(SLICES);
    assign seq_ok   = {16'd0, hdr.slice_seq} < 32'(SLICES);

    assign hdr_ok = len_ok && total_ok && seq_ok
                 && (hdr.magic_word == MAGIC_VALUE)
                 && (hdr.proto_version == VERSION_VALUE)
                 && (hdr.packet_kind == KIND_CHUNK);

endmodule

@@ design/datagram_slice_reassembly_tracker.sv @@
// Slice reassembly tracker: context scan sequencer, slice mask memory and result register.
// Packet transfer: the scan state visits one context per cycle through a single age/key
// compare unit, then S_LOOKUP, S_UPDATE and S_OUT; a malformed packet goes straight to S_OUT.
// Tick transfer: counted in S_IDLE, no result. Next item accepted in the cycle after the
// result is loaded, which waits in S_OUT while the result register is held by m_tready low.
// Reset (aresetn low, synchronous): no live contexts, tick count 0, timeout 5000, no result.
module datagram_slice_reassembly_tracker (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // byte_length, magic_word, proto_version, packet_kind, coord_x, coord_z,
    // slice_seq, slice_total
    input  logic [dsrt_pkg::S_DATA_W-1:0] s_tdata,
    // operation
    input  logic                          s_tuser,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // status, context_slot, slice_index, expired_count
    output logic [dsrt_pkg::M_DATA_W-1:0] m_tdata,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [31:0]                   cfg_data
);
    import dsrt_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_LOOKUP,
        S_UPDATE,
        S_OUT
    } state_t;

    state_t                  state_reg;
    logic [CTX_W-1:0]        scan_idx_reg;
    logic [31:0]             tick_now_reg;
    logic [31:0]             timeout_reg;
    logic [CONTEXTS-1:0]     ctx_valid_reg;
    logic [63:0]             ctx_key_reg   [CONTEXTS];
    logic [31:0]             ctx_first_reg [CONTEXTS];
    logic [RCV_W-1:0]        ctx_rcv_reg   [CONTEXTS];
    logic [SLICES-1:0]       mask_mem      [CONTEXTS];
    logic [SLICES-1:0]       mask_rd_reg;

    logic [63:0]             key_reg;
    logic [15:0]             seq_reg;
    logic [3:0]              expired_reg;
    logic                    found_reg;
    logic [CTX_W-1:0]        found_idx_reg;
    logic                    free_reg;
    logic [CTX_W-1:0]        free_idx_reg;
    logic                    alloc_reg;
    logic [CTX_W-1:0]        slot_reg;
    status_t                 res_status_reg;
    logic [2:0]              res_slot_reg;
    logic                    m_tvalid_reg;
    logic [M_DATA_W-1:0]     m_tdata_reg;

    hdr_t                    hdr;
    logic                    hdr_ok;
    logic [31:0]             age;
    logic                    expire;
    logic                    live;
    logic                    hit;
    logic [CTX_W-1:0]        lookup_slot;
    logic [SEQ_W-1:0]        seq_idx;
    logic                    seen;
    logic [RCV_W-1:0]        rcv_next;
    logic [SLICES-1:0]       mask_next;
    logic                    mask_we;
    logic                    out_free;

    assign hdr.byte_length   = s_tdata[8:0];
    assign hdr.magic_word    = s_tdata[24:9];
    assign hdr.proto_version = s_tdata[32:25];
    assign hdr.packet_kind   = s_tdata[40:33];
    assign hdr.coord_x       = s_tdata[72:41];
    assign hdr.coord_z       = s_tdata[104:73];
    assign hdr.slice_seq     = s_tdata[120:105];
    assign hdr.slice_total   = s_tdata[136:121];

    dsrt_hdr_check u_hdr_check (
        .hdr    (hdr),
        .hdr_ok (hdr_ok)
    );

    // shared scan unit: one context per cycle
    assign age    = tick_now_reg - ctx_first_reg[scan_idx_reg];
    assign expire = ctx_valid_reg[scan_idx_reg] && (age > timeout_reg);
    assign live   = ctx_valid_reg[scan_idx_reg] && !expire;
    assign hit    = live && (ctx_key_reg[scan_idx_reg] == key_reg);

    assign lookup_slot = found_reg ? found_idx_reg : free_idx_reg;
    assign seq_idx     = seq_reg[SEQ_W-1:0];
    assign seen        = !alloc_reg && mask_rd_reg[seq_idx];
    assign rcv_next    = (alloc_reg ? '0 : ctx_rcv_reg[slot_reg]) + RCV_W'(1);
    assign mask_next   = (alloc_reg ? '0 : mask_rd_reg)
                       | ({{(SLICES-1){1'b0}}, 1'b1} << seq_idx);
    assign mask_we     = (state_reg == S_UPDATE) && !seen;
    assign out_free    = !m_tvalid_reg || m_tready;

    always_ff @(posedge aclk) begin
        mask_rd_reg <= mask_mem[lookup_slot];
        if (mask_we) begin
            mask_mem[slot_reg] <= mask_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            scan_idx_reg  <= '0;
            tick_now_reg  <= '0;
            timeout_reg   <= 32'd5000;
            ctx_valid_reg <= '0;
            m_tvalid_reg  <= 1'b0;
        end else begin
            if (cfg_valid) begin
                timeout_reg <= cfg_data;
            end

            if (state_reg == S_OUT && out_free) begin
                m_tvalid_reg <= 1'b1;
                m_tdata_reg  <= {6'd0, expired_reg, seq_reg[7:0], res_slot_reg, res_status_reg};
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE: begin
                    if (s_tvalid) begin
                        if (s_tuser == OP_TICK) begin
                            tick_now_reg <= tick_now_reg + 32'd1;
                        end else begin
                            key_reg      <= {hdr.coord_x, hdr.coord_z};
                            expired_reg  <= '0;
                            found_reg    <= 1'b0;
                            free_reg     <= 1'b0;
                            scan_idx_reg <= '0;
                            if (hdr_ok) begin
                                seq_reg   <= hdr.slice_seq;
                                state_reg <= S_SCAN;
                            end else begin
                                seq_reg        <= '0;
                                res_status_reg <= ST_MALFORMED;
                                res_slot_reg   <= '0;
                                state_reg      <= S_OUT;
                            end
                        end
                    end
                end
                S_SCAN: begin
                    if (expire) begin
                        ctx_valid_reg[scan_idx_reg] <= 1'b0;
                        if (expired_reg != 4'hF) begin
                            expired_reg <= expired_reg + 4'd1;
                        end
                    end
                    if (hit && !found_reg) begin
                        found_reg     <= 1'b1;
                        found_idx_reg <= scan_idx_reg;
                    end
                    if (!live && !free_reg) begin
                        free_reg     <= 1'b1;
                        free_idx_reg <= scan_idx_reg;
                    end
                    if (scan_idx_reg == CTX_W'(CONTEXTS - 1)) begin
                        state_reg <= S_LOOKUP;
                    end else begin
                        scan_idx_reg <= scan_idx_reg + CTX_W'(1);
                    end
                end
                S_LOOKUP: begin
                    if (found_reg) begin
                        slot_reg  <= found_idx_reg;
                        alloc_reg <= 1'b0;
                        state_reg <= S_UPDATE;
                    end else if (free_reg) begin
                        slot_reg                    <= free_idx_reg;
                        alloc_reg                   <= 1'b1;
                        ctx_valid_reg[free_idx_reg] <= 1'b1;
                        ctx_key_reg[free_idx_reg]   <= key_reg;
                        ctx_first_reg[free_idx_reg] <= tick_now_reg;
                        state_reg                   <= S_UPDATE;
                    end else begin
                        res_status_reg <= ST_FULL;
                        res_slot_reg   <= '0;
                        state_reg      <= S_OUT;
                    end
                end
                S_UPDATE: begin
                    res_slot_reg <= 3'(slot_reg);
                    if (seen) begin
                        res_status_reg <= ST_DUP;
                    end else begin
                        ctx_rcv_reg[slot_reg] <= rcv_next;
                        if (rcv_next == RCV_W'(SLICES)) begin
                            ctx_valid_reg[slot_reg] <= 1'b0;
                            res_status_reg          <= ST_DONE;
                        end else begin
                            res_status_reg <= ST_NEW;
                        end
                    end
                    state_reg <= S_OUT;
                end
                S_OUT: begin
                    if (out_free) begin
                        state_reg <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign s_tready  = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;

endmodule

@@ design/dsrt_checker.sv @@
// Port-level checker for the datagram slice reassembly tracker, bound to the top level.
module dsrt_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_tvalid,
    input logic                          s_tready,
    input logic                          s_tuser,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [dsrt_pkg::M_DATA_W-1:0] m_tdata
);
    import dsrt_pkg::*;

    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    a_malformed_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tdata[2:0] == ST_MALFORMED) |-> (m_tdata[17:3] == 15'd0))
        else $error("malformed result carries nonzero fields");

    a_full_slot_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tdata[2:0] == ST_FULL) |-> (m_tdata[5:3] == 3'd0))
        else $error("table full result carries a slot");

    a_busy_after_packet: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && (s_tuser == OP_PACKET) |=> !s_tready)
        else $error("ready right after packet transfer");

    a_tick_silent: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && (s_tuser == OP_TICK) && !m_tvalid |=> !m_tvalid)
        else $error("tick transfer produced a result");

endmodule

bind datagram_slice_reassembly_tracker dsrt_checker u_dsrt_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

@@ tb/tb_datagram_slice_reassembly_tracker.sv @@
// Self-checking testbench for the datagram slice reassembly tracker, with predictor and scoreboard.
module tb_datagram_slice_reassembly_tracker;
    import dsrt_pkg::*;

    localparam int CYCLE_LIMIT = 600000;
    localparam int SETTLE_CYCLES = 24;
    localparam logic [8:0] GOOD_LENGTH = 9'(HEADER_BYTES + SLICE_BYTES);

    typedef struct {
        status_t     status;
        logic [2:0]  slot;
        logic [7:0]  slice;
        logic [3:0]  expired;
    } result_t;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [S_DATA_W-1:0]   s_tdata = '0;
    logic                  s_tuser = OP_PACKET;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [M_DATA_W-1:0]   m_tdata;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [31:0]           cfg_data = '0;

    datagram_slice_reassembly_tracker dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // tracker image
    logic [31:0]  trk_timeout = 32'd5000;
    logic [31:0]  trk_ticks = '0;
    logic         trk_live [CONTEXTS];
    logic [63:0]  trk_key [CONTEXTS];
    logic [31:0]  trk_born [CONTEXTS];
    logic [SLICES-1:0] trk_mask [CONTEXTS];
    int           trk_count [CONTEXTS];

    result_t      pending_results[$];
    int           fail_count = 0;
    int           mismatch_count = 0;
    int           cycle_count = 0;
    bit           burst_mode = 1'b0;
    int           hold_request = 0;

    initial begin
        for (int i = 0; i < CONTEXTS; i++) begin
            trk_live[i] = 1'b0;
            trk_key[i] = '0;
            trk_born[i] = '0;
            trk_mask[i] = '0;
            trk_count[i] = 0;
        end
    end

    function automatic logic [S_DATA_W-1:0] pack_header(input hdr_t h);
        return {7'b0, h.slice_total, h.slice_seq, h.coord_z, h.coord_x,
                h.packet_kind, h.proto_version, h.magic_word, h.byte_length};
    endfunction

    function automatic hdr_t good_header(input logic [31:0] x, input logic [31:0] z,
                                         input int seq);
        hdr_t h;
        h.byte_length = GOOD_LENGTH;
        h.magic_word = MAGIC_VALUE;
        h.proto_version = VERSION_VALUE;
        h.packet_kind = KIND_CHUNK;
        h.coord_x = x;
        h.coord_z = z;
        h.slice_seq = 16'(seq);
        h.slice_total = 16'(SLICES);
        return h;
    endfunction

    function automatic hdr_t broken_header(input hdr_t base);
        hdr_t h;
        h = base;
        case ($urandom_range(0, 7))
            0: begin
                h.byte_length = 9'($urandom_range(0, 336));
                h.magic_word = 16'($urandom);
                h.proto_version = 8'($urandom);
                h.packet_kind = 8'($urandom);
                h.coord_x = $urandom;
                h.coord_z = $urandom;
                h.slice_seq = 16'($urandom);
                h.slice_total = 16'($urandom);
            end
            1: h.byte_length = 9'($urandom_range(0, 336));
            2: h.magic_word = 16'($urandom);
            3: h.proto_version = 8'($urandom);
            4: h.packet_kind = 8'($urandom);
            5: h.slice_total = 16'($urandom);
            6: h.slice_seq = 16'($urandom_range(SLICES, 65535));
            default: begin
                h.magic_word = 16'($urandom);
                h.slice_seq = 16'($urandom);
                h.slice_total = 16'($urandom);
            end
        endcase
        return h;
    endfunction

    function automatic void shuffle_slices(output int order[SLICES]);
        int j;
        int t;
        for (int i = 0; i < SLICES; i++) order[i] = i;
        for (int i = SLICES - 1; i > 0; i--) begin
            j = $urandom_range(0, i);
            t = order[i];
            order[i] = order[j];
            order[j] = t;
        end
    endfunction

    function automatic void expect_result(input result_t r);
        pending_results.insert(pending_results.size(), r);
    endfunction

    function automatic void track_item(input logic op, input logic [S_DATA_W-1:0] d);
        result_t     r;
        logic [8:0]  len;
        logic [15:0] magic;
        logic [7:0]  ver;
        logic [7:0]  kind;
        logic [15:0] seq;
        logic [15:0] total;
        logic [63:0] key;
        logic [31:0] age;
        int          hit;
        int          vacant;
        int          expired;
        if (op == OP_TICK) begin
            trk_ticks = trk_ticks + 32'd1;
            return;
        end
        len = d[8:0];
        magic = d[24:9];
        ver = d[32:25];
        kind = d[40:33];
        key = {d[72:41], d[104:73]};
        seq = d[120:105];
        total = d[136:121];
        hit = -1;
        vacant = -1;
        expired = 0;
        r.slot = '0;
        r.slice = '0;
        r.expired = '0;
        if (len != GOOD_LENGTH || magic != MAGIC_VALUE || ver != VERSION_VALUE ||
            kind != KIND_CHUNK || total != 16'(SLICES) || seq >= 16'(SLICES)) begin
            r.status = ST_MALFORMED;
            expect_result(r);
            return;
        end
        for (int i = 0; i < CONTEXTS; i++) begin
            age = trk_ticks - trk_born[i];
            if (trk_live[i] && age > trk_timeout) begin
                trk_live[i] = 1'b0;
                if (expired < 15) expired++;
            end
        end
        for (int i = 0; i < CONTEXTS; i++) begin
            if (trk_live[i]) begin
                if (hit < 0 && trk_key[i] == key) hit = i;
            end else if (vacant < 0) begin
                vacant = i;
            end
        end
        r.slice = seq[7:0];
        r.expired = 4'(expired);
        if (hit < 0) begin
            if (vacant < 0) begin
                r.status = ST_FULL;
                expect_result(r);
                return;
            end
            hit = vacant;
            trk_live[hit] = 1'b1;
            trk_key[hit] = key;
            trk_born[hit] = trk_ticks;
            trk_mask[hit] = '0;
            trk_count[hit] = 0;
        end
        r.slot = 3'(hit);
        if (trk_mask[hit][seq[SEQ_W-1:0]]) begin
            r.status = ST_DUP;
        end else begin
            trk_mask[hit][seq[SEQ_W-1:0]] = 1'b1;
            trk_count[hit]++;
            if (trk_count[hit] >= SLICES) begin
                trk_live[hit] = 1'b0;
                r.status = ST_DONE;
            end else begin
                r.status = ST_NEW;
            end
        end
        expect_result(r);
    endfunction

    function automatic void check_result(input logic [M_DATA_W-1:0] d);
        result_t want;
        if (pending_results.size() == 0) begin
            fail_count++;
            mismatch_count++;
            if (mismatch_count <= 10)
                $display("unexpected result transfer: tdata=%h", d);
            return;
        end
        want = pending_results.pop_front();
        if (d[2:0] !== want.status || d[5:3] !== want.slot || d[13:6] !== want.slice ||
            d[17:14] !== want.expired) begin
            fail_count++;
            mismatch_count++;
            if (mismatch_count <= 10)
                $display("result mismatch: expected status=%0d slot=%0d slice=%0d expired=%0d, %s",
                         want.status, want.slot, want.slice, want.expired,
                         $sformatf("got status=%0d slot=%0d slice=%0d expired=%0d",
                                   d[2:0], d[5:3], d[13:6], d[17:14]));
        end
    endfunction

    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_tvalid && m_tready) check_result(m_tdata);
            if (s_tvalid && s_tready) track_item(s_tuser, s_tdata);
            if (cfg_valid && cfg_ready) trk_timeout = cfg_data;
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("datagram_slice_reassembly_tracker verification failed");
            $finish;
        end
    end

    // result receiver: random hold-off per transfer (none in burst mode), or one long hold on request
    initial begin
        int wait_cycles;
        wait (aresetn);
        @(posedge aclk);
        forever begin
            wait_cycles = burst_mode ? 0 : $urandom_range(0, 6);
            if (hold_request > 0) begin
                wait_cycles = hold_request;
                hold_request = 0;
            end
            if (wait_cycles > 0) begin
                m_tready <= 1'b0;
                repeat (wait_cycles) @(posedge aclk);
            end
            m_tready <= 1'b1;
            @(posedge aclk);
            while (!m_tvalid) @(posedge aclk);
        end
    end

    task automatic send_item(input logic op, input hdr_t h);
        int gap;
        s_tuser <= op;
        s_tdata <= pack_header(h);
        s_tvalid <= 1'b1;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        gap = burst_mode ? 0 : $urandom_range(0, 6);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    task automatic send_tick();
        send_item(OP_TICK, broken_header(good_header('0, '0, 0)));
    endtask

    task automatic settle_results();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_timeout(input logic [31:0] value);
        settle_results();
        cfg_data <= value;
        cfg_valid <= 1'b1;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic test_header_checks();
        hdr_t h;
        hdr_t base;
        base = good_header(32'h1234_5678, 32'h9abc_def0, 7);
        h = base; h.byte_length = 9'd0;   send_item(OP_PACKET, h);
        h = base; h.byte_length = 9'd15;  send_item(OP_PACKET, h);
        h = base; h.byte_length = 9'd16;  send_item(OP_PACKET, h);
        h = base; h.byte_length = 9'd271; send_item(OP_PACKET, h);
        h = base; h.byte_length = 9'd273; send_item(OP_PACKET, h);
        h = base; h.byte_length = 9'd336; send_item(OP_PACKET, h);
        h = base; h.magic_word = 16'h0000; send_item(OP_PACKET, h);
        h = base; h.magic_word = 16'hffff; send_item(OP_PACKET, h);
        h = base; h.proto_version = 8'd0;   send_item(OP_PACKET, h);
        h = base; h.proto_version = 8'd255; send_item(OP_PACKET, h);
        h = base; h.packet_kind = 8'd0;     send_item(OP_PACKET, h);
        h = base; h.packet_kind = 8'd255;   send_item(OP_PACKET, h);
        h = base; h.slice_total = 16'd0;     send_item(OP_PACKET, h);
        h = base; h.slice_total = 16'd255;   send_item(OP_PACKET, h);
        h = base; h.slice_total = 16'hffff;  send_item(OP_PACKET, h);
        h = base; h.slice_seq = 16'd256;     send_item(OP_PACKET, h);
        h = base; h.slice_seq = 16'hffff;    send_item(OP_PACKET, h);
        send_item(OP_PACKET, good_header(32'h8000_0000, 32'h7fff_ffff, 0));
        send_item(OP_PACKET, good_header(32'h7fff_ffff, 32'h8000_0000, SLICES - 1));
        send_item(OP_PACKET, good_header(32'h8000_0000, 32'h7fff_ffff, 0));
        send_tick();
        send_item(OP_PACKET, good_header(32'h0, 32'h0, 128));
    endtask

    task automatic test_table_full();
        for (int i = 3; i < CONTEXTS; i++)
            send_item(OP_PACKET, good_header(32'h100 + i, -i, i));
        send_item(OP_PACKET, good_header(32'hdead_0009, 32'h0000_0009, 200));
        send_item(OP_PACKET, good_header(32'h8000_0000, 32'h7fff_ffff, SLICES - 1));
        send_item(OP_PACKET, good_header(32'h0, 32'h0, 128));
        send_item(OP_PACKET, good_header(32'hffff_ffff, 32'hffff_ffff, 77));
    endtask

    task automatic test_zero_timeout();
        write_timeout(32'd0);
        send_tick();
        send_item(OP_PACKET, good_header(32'h0000_0aaa, 32'h0000_0bbb, 10));
        send_item(OP_PACKET, good_header(32'h0000_0aaa, 32'h0000_0bbb, 11));
        write_timeout(32'd1);
        send_tick();
        send_item(OP_PACKET, good_header(32'h0000_0aaa, 32'h0000_0bbb, 12));
        send_tick();
        send_item(OP_PACKET, good_header(32'h0000_0ccc, 32'h0000_0ddd, 13));
    endtask

    task automatic test_slice_completion();
        int order[SLICES];
        logic [31:0] x;
        logic [31:0] z;
        write_timeout(32'hffff_ffff);
        shuffle_slices(order);
        x = $urandom;
        z = $urandom;
        for (int k = 0; k < SLICES; k++) begin
            send_item(OP_PACKET, good_header(x, z, order[k]));
            if (k % 32 == 31) begin
                send_item(OP_PACKET, good_header(x, z, order[$urandom_range(0, k)]));
                send_tick();
            end
        end
        send_item(OP_PACKET, good_header(x, z, order[0]));
    endtask

    task automatic test_stalled_receiver();
        settle_results();
        hold_request = 400;
        burst_mode = 1'b1;
        for (int i = 0; i < 40; i++) begin
            if (i % 9 == 4)
                send_tick();
            else
                send_item(OP_PACKET, good_header(32'h55 + (i % 5), 32'h66, $urandom_range(0, 255)));
        end
        burst_mode = 1'b0;
    endtask

    task automatic test_random_traffic();
        logic [31:0] phase_timeout [3];
        int          tick_pct [3];
        logic [31:0] cold_x [10];
        logic [31:0] cold_z [10];
        int          order[SLICES];
        int          hot_pos;
        logic [31:0] hot_x;
        logic [31:0] hot_z;
        int          r;
        int          c;
        phase_timeout[0] = 32'hffff_ffff;
        phase_timeout[1] = $urandom_range(5000, 32'hffff_ffff);
        phase_timeout[2] = 32'd30;
        tick_pct[0] = 6;
        tick_pct[1] = 6;
        tick_pct[2] = 15;
        for (int i = 0; i < 10; i++) begin
            cold_x[i] = $urandom;
            cold_z[i] = $urandom;
        end
        for (int p = 0; p < 3; p++) begin
            write_timeout(phase_timeout[p]);
            shuffle_slices(order);
            hot_pos = 0;
            hot_x = $urandom;
            hot_z = $urandom;
            for (int n = 0; n < 480; n++) begin
                burst_mode = (n >= 250 && n < 320);
                r = $urandom_range(0, 99);
                c = $urandom_range(0, 9);
                if (r < tick_pct[p]) begin
                    send_tick();
                end else if (r < tick_pct[p] + 10) begin
                    send_item(OP_PACKET,
                              broken_header(good_header(cold_x[c], cold_z[c], c)));
                end else if (r < tick_pct[p] + 60) begin
                    if ($urandom_range(0, 9) == 0) begin
                        send_item(OP_PACKET, good_header(hot_x, hot_z, $urandom_range(0, 255)));
                    end else begin
                        send_item(OP_PACKET, good_header(hot_x, hot_z, order[hot_pos]));
                        hot_pos++;
                        if (hot_pos == SLICES) begin
                            shuffle_slices(order);
                            hot_pos = 0;
                            hot_x = $urandom;
                            hot_z = $urandom;
                        end
                    end
                end else begin
                    send_item(OP_PACKET,
                              good_header(cold_x[c], cold_z[c], $urandom_range(0, 255)));
                end
            end
            burst_mode = 1'b0;
        end
    endtask

    initial begin
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        test_header_checks();
        test_table_full();
        test_zero_timeout();
        test_slice_completion();
        test_stalled_receiver();
        test_random_traffic();
        settle_results();
        if (pending_results.size() != 0) fail_count++;
        if (fail_count == 0) begin
            $display("datagram_slice_reassembly_tracker verification clean");
        end else begin
            $display("datagram_slice_reassembly_tracker verification failed");
        end
        $finish;
    end

endmodule
